// ===== hdl/escp_pkg.sv =====
// Shared constants, types and register codes of the telemetry frame parser.
package escp_pkg;

  localparam int unsigned FRAME_BYTES = 24;
  localparam logic [7:0] HDR_FIRST = 8'd155;
  localparam logic [7:0] HDR_SECOND = 8'd22;

  localparam int unsigned OFS_COUNTER = 4;
  localparam int unsigned OFS_THROTTLE = 6;
  localparam int unsigned OFS_RPM = 10;
  localparam int unsigned OFS_VOLTAGE = 12;
  localparam int unsigned OFS_CURRENT = 14;
  localparam int unsigned OFS_TEMP = 18;

  localparam int unsigned GAIN_W = 36;
  localparam int unsigned OFFS_W = 32;
  localparam int unsigned Q_W = 44;
  localparam int unsigned TEMP_W = 45;
  localparam int unsigned PROD_W = 36;
  localparam int unsigned ACC_W = 54;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TDATA_W = 240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_GAIN   = 3'd0,
    REG_RPM_GAIN       = 3'd1,
    REG_CURRENT_GAIN   = 3'd2,
    REG_THROTTLE_GAIN  = 3'd3,
    REG_TEMP_SCALE     = 3'd4,
    REG_TEMP_OFFSET    = 3'd5,
    REG_TEMP_BITS_MASK = 3'd6,
    REG_POLE_COUNT     = 3'd7
  } escp_reg_e;

  typedef enum logic [2:0] {
    OP_RPM      = 3'd0,
    OP_VOLTAGE  = 3'd1,
    OP_CURRENT  = 3'd2,
    OP_TEMP     = 3'd3,
    OP_THROTTLE = 3'd4
  } escp_op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] voltage_gain;
    logic [GAIN_W-1:0] rpm_gain;
    logic [GAIN_W-1:0] current_gain;
    logic [GAIN_W-1:0] throttle_gain;
    logic [GAIN_W-1:0] temp_scale;
    logic [OFFS_W-1:0] temp_offset;
    logic [15:0]       temp_bits_mask;
    logic [7:0]        pole_count;
  } escp_cfg_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] temp;
    logic [15:0] throttle;
  } escp_raw_t;

  typedef struct packed {
    logic [Q_W-1:0]    speed_rpm;
    logic [Q_W-1:0]    bus_voltage;
    logic [Q_W-1:0]    bus_current;
    logic [TEMP_W-1:0] temperature_k;
    logic [Q_W-1:0]    throttle_pct;
  } escp_res_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } escp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } escp_stat_t;

endpackage

// ===== hdl/esc_telemetry_frame_parser_core.sv =====
// Top level of the telemetry frame parser: byte window, registers and result beat.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] data_byte; tuser evaluate
//  m_axis    out        tdata: frame_counter, speed_rpm, bus_voltage, bus_current,
//                       temperature_k, throttle_pct (lowest bits first)
//  cfg       in         write enable, register index, 36-bit write data
//
// A beat that does not start a decode only shifts the byte window. A beat with evaluate
// set that finds the header keeps the engine busy: the shared multiplier forms each of
// five products from a low and a high partial product, the pole divider works out the
// rpm quotient one quotient bit per cycle, and the engine then hands the result over.
// The input is not ready while the engine works; a finished result waits in the
// output register without blocking the next input beat, but a further result holds
// the engine, and the input, until that register is free.
// Reset clears the byte window, the control state and loads the register defaults.
module esc_telemetry_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // data_byte[7:0]
  input  logic                          s_axis_tuser_i,  // evaluate
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // frame_counter[15:0], speed_rpm[59:16], bus_voltage[103:60], bus_current[147:104],
  // temperature_k[192:148], throttle_pct[236:193], zero padding[239:237]
  output logic [escp_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [escp_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [escp_pkg::GAIN_W-1:0]   cfg_wdata_i
);
  import escp_pkg::*;

  logic [FRAME_BYTES-1:0][7:0] win_q, win_d;
  escp_cfg_t                   cfg_q, cfg_d;
  logic                        out_valid_q, out_valid_d;
  logic [TDATA_W-1:0]          out_data_q, out_data_d;

  escp_ctrl_t ctrl;
  escp_stat_t stat;
  escp_raw_t  raw;
  escp_res_t  res;
  logic       in_acc;
  logic       hdr_hit;
  logic       load;
  logic [15:0] counter;

  assign s_axis_tready_o = !stat.busy;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign hdr_hit = (win_q[1] == HDR_FIRST) && (win_q[2] == HDR_SECOND);
  assign win_d   = in_acc ? {s_axis_tdata_i, win_q[FRAME_BYTES-1:1]} : win_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (escp_reg_e'(cfg_addr_i))
        REG_VOLTAGE_GAIN:   cfg_d.voltage_gain   = cfg_wdata_i;
        REG_RPM_GAIN:       cfg_d.rpm_gain       = cfg_wdata_i;
        REG_CURRENT_GAIN:   cfg_d.current_gain   = cfg_wdata_i;
        REG_THROTTLE_GAIN:  cfg_d.throttle_gain  = cfg_wdata_i;
        REG_TEMP_SCALE:     cfg_d.temp_scale     = cfg_wdata_i;
        REG_TEMP_OFFSET:    cfg_d.temp_offset    = cfg_wdata_i[OFFS_W-1:0];
        REG_TEMP_BITS_MASK: cfg_d.temp_bits_mask = cfg_wdata_i[15:0];
        REG_POLE_COUNT:     cfg_d.pole_count     = cfg_wdata_i[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  assign raw.rpm      = {win_q[OFS_RPM],      win_q[OFS_RPM+1]};
  assign raw.voltage  = {win_q[OFS_VOLTAGE],  win_q[OFS_VOLTAGE+1]};
  assign raw.current  = {win_q[OFS_CURRENT],  win_q[OFS_CURRENT+1]};
  assign raw.temp     = {win_q[OFS_TEMP],     win_q[OFS_TEMP+1]};
  assign raw.throttle = {win_q[OFS_THROTTLE], win_q[OFS_THROTTLE+1]};
  assign counter      = {win_q[OFS_COUNTER],  win_q[OFS_COUNTER+1]};

  assign ctrl.start    = in_acc && s_axis_tuser_i && hdr_hit;
  assign ctrl.out_free = !out_valid_q || m_axis_tready_i;
  assign load          = stat.done && ctrl.out_free;

  escp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .raw_i  (raw),
    .stat_o (stat),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'd0, res.throttle_pct, res.temperature_k, res.bus_current,
                     res.bus_voltage, res.speed_rpm, counter};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q                <= '0;
      cfg_q.voltage_gain   <= GAIN_W'(16777216);
      cfg_q.rpm_gain       <= GAIN_W'(16777216);
      cfg_q.current_gain   <= GAIN_W'(16777216);
      cfg_q.throttle_gain  <= GAIN_W'(16777216);
      cfg_q.temp_scale     <= GAIN_W'(16777216);
      cfg_q.temp_offset    <= '0;
      cfg_q.temp_bits_mask <= 16'hFFFF;
      cfg_q.pole_count     <= 8'd1;
      out_valid_q          <= 1'b0;
    end else begin
      win_q       <= win_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |=> stat.busy)
    else $error("engine did not start on a header beat");

  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |=> $stable(win_q))
    else $error("byte window moved while the engine was working");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.done && ctrl.out_free) |=> (m_axis_tvalid_o && !stat.done))
    else $error("finished result not moved into the output register");

endmodule

// ===== hdl/escp_engine.sv =====
// Sequenced scaling engine: one shared 17x19 multiplier and a radix-2 pole divider.
module escp_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  escp_pkg::escp_ctrl_t ctrl_i,
  input  escp_pkg::escp_cfg_t  cfg_i,
  input  escp_pkg::escp_raw_t  raw_i,
  output escp_pkg::escp_stat_t stat_o,
  output escp_pkg::escp_res_t  res_o
);
  import escp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam int unsigned CNT_W = $clog2(Q_W);

  logic [1:0]              st_q, st_d;
  escp_op_e                op_q, op_d;
  logic [1:0]              phase_q, phase_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [Q_W-1:0]          quo_q, quo_d;
  logic [7:0]              rem_q, rem_d;
  logic [Q_W-1:0]          volt_q, volt_d;
  logic [Q_W-1:0]          curr_q, curr_d;
  logic [TEMP_W-1:0]       temp_q, temp_d;
  logic [Q_W-1:0]          thr_q, thr_d;

  logic [15:0]             raw;
  logic [GAIN_W-1:0]       gain;
  logic                    op_signed;
  logic signed [16:0]      mul_a;
  logic signed [18:0]      mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] offs_ext;
  logic signed [ACC_W-1:0] acc_hi;
  logic signed [ACC_W-1:0] temp_round;
  logic [7:0]              divisor;
  logic [8:0]              shifted;
  logic [8:0]              diff;
  logic                    ge;

  always_comb begin
    case (op_q)
      OP_RPM: begin
        raw  = raw_i.rpm;
        gain = cfg_i.rpm_gain;
      end
      OP_VOLTAGE: begin
        raw  = raw_i.voltage;
        gain = cfg_i.voltage_gain;
      end
      OP_CURRENT: begin
        raw  = raw_i.current;
        gain = cfg_i.current_gain;
      end
      OP_TEMP: begin
        raw  = raw_i.temp & cfg_i.temp_bits_mask;
        gain = cfg_i.temp_scale;
      end
      OP_THROTTLE: begin
        raw  = raw_i.throttle;
        gain = cfg_i.throttle_gain;
      end
      default: begin
        raw  = raw_i.rpm;
        gain = cfg_i.rpm_gain;
      end
    endcase
  end

  assign op_signed = (op_q == OP_TEMP);
  assign mul_a = $signed({1'b0, raw});
  assign mul_b = (phase_q == 2'd0) ? $signed({1'b0, gain[17:0]})
                                   : $signed({op_signed & gain[GAIN_W-1], gain[GAIN_W-1:18]});
  assign mul_p = mul_a * mul_b;

  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
  assign offs_ext = op_signed
                  ? $signed({{(ACC_W-OFFS_W-8){cfg_i.temp_offset[OFFS_W-1]}},
                             cfg_i.temp_offset, 8'd0})
                  : '0;
  assign acc_hi = acc_q + $signed({prod_q, 18'd0});
  assign temp_round = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

  assign divisor = (cfg_i.pole_count == 8'd0) ? 8'd1 : cfg_i.pole_count;
  assign shifted = {rem_q, quo_q[Q_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = (shifted >= {1'b0, divisor});

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    volt_d  = volt_q;
    curr_d  = curr_q;
    temp_d  = temp_q;
    thr_d   = thr_q;
    unique case (st_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          st_d    = ST_MUL;
          op_d    = OP_RPM;
          phase_d = 2'd0;
        end
      end
      ST_MUL: begin
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: prod_d = mul_p;
          2'd1: begin
            acc_d  = prod_ext + offs_ext;
            prod_d = mul_p;
          end
          2'd2: acc_d = acc_hi;
          2'd3: begin
            case (op_q)
              OP_RPM: begin
                quo_d = acc_q[Q_W+7:8];
                rem_d = '0;
                cnt_d = '0;
                st_d  = ST_DIV;
                op_d  = OP_VOLTAGE;
              end
              OP_VOLTAGE: begin
                volt_d = acc_q[Q_W+7:8];
                op_d   = OP_CURRENT;
              end
              OP_CURRENT: begin
                curr_d = acc_q[Q_W+7:8];
                op_d   = OP_TEMP;
              end
              OP_TEMP: begin
                temp_d = temp_round[TEMP_W+7:8];
                op_d   = OP_THROTTLE;
              end
              default: begin
                thr_d = acc_q[Q_W+7:8];
                st_d  = ST_DONE;
              end
            endcase
          end
          default: phase_d = 2'd0;
        endcase
      end
      ST_DIV: begin
        quo_d = {quo_q[Q_W-2:0], ge};
        rem_d = ge ? diff[7:0] : shifted[7:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          st_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (ctrl_i.out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      op_q    <= OP_RPM;
      phase_q <= 2'd0;
      cnt_q   <= '0;
    end else begin
      st_q    <= st_d;
      op_q    <= op_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    volt_q <= volt_d;
    curr_q <= curr_d;
    temp_q <= temp_d;
    thr_q  <= thr_d;
  end

  assign stat_o.busy = (st_q != ST_IDLE);
  assign stat_o.done = (st_q == ST_DONE);

  assign res_o.speed_rpm     = quo_q;
  assign res_o.bus_voltage   = volt_q;
  assign res_o.bus_current   = curr_q;
  assign res_o.temperature_k = temp_q;
  assign res_o.throttle_pct  = thr_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the telemetry frame parser: byte beats in, decoded frames compared.
`timescale 1ns / 100ps

module testbench;
  import escp_pkg::*;

  localparam int unsigned LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [15:0]       counter;
    logic [Q_W-1:0]    speed;
    logic [Q_W-1:0]    voltage;
    logic [Q_W-1:0]    current;
    logic [TEMP_W-1:0] temp;
    logic [Q_W-1:0]    throttle;
  } tel_frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 s_valid;
  logic                 s_ready;
  logic [7:0]           s_data;
  logic                 s_user;
  logic                 m_valid;
  logic                 m_ready;
  logic [TDATA_W-1:0]   m_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [GAIN_W-1:0]    cfg_wdata;

  logic [7:0]  win_bytes [FRAME_BYTES];
  escp_cfg_t   cfg_model;
  tel_frame_t  frames_due [$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned sink_hold_left = 0;
  int unsigned sink_stall_left = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  esc_telemetry_frame_parser_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [15:0] pick16();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'(1) << $urandom_range(0, 15);
    return 16'($urandom);
  endfunction

  function automatic logic [GAIN_W-1:0] rand36();
    return {4'($urandom_range(0, 15)), 32'($urandom)};
  endfunction

  function automatic logic [15:0] be16(int unsigned pos);
    return {win_bytes[pos], win_bytes[pos+1]};
  endfunction

  function automatic tel_frame_t decode_frame();
    tel_frame_t  f;
    logic [63:0] poles;
    logic [63:0] mag;
    longint      slope;
    longint      offs;
    longint      raw_t;
    longint      sum;
    poles = (cfg_model.pole_count == 8'd0) ? 64'd1 : 64'(cfg_model.pole_count);
    f.counter = be16(OFS_COUNTER);
    f.speed = Q_W'(((64'(be16(OFS_RPM)) * 64'(cfg_model.rpm_gain)) / poles) >> 8);
    f.voltage = Q_W'((64'(be16(OFS_VOLTAGE)) * 64'(cfg_model.voltage_gain)) >> 8);
    f.current = Q_W'((64'(be16(OFS_CURRENT)) * 64'(cfg_model.current_gain)) >> 8);
    f.throttle = Q_W'((64'(be16(OFS_THROTTLE)) * 64'(cfg_model.throttle_gain)) >> 8);
    raw_t = {48'd0, be16(OFS_TEMP) & cfg_model.temp_bits_mask};
    slope = {{28{cfg_model.temp_scale[GAIN_W-1]}}, cfg_model.temp_scale};
    offs = {{32{cfg_model.temp_offset[OFFS_W-1]}}, cfg_model.temp_offset};
    sum = raw_t * slope + offs * 256;
    if (sum < 0) begin
      mag = 64'(-sum) >> 8;
      f.temp = TEMP_W'(64'd0 - mag);
    end else begin
      f.temp = TEMP_W'(64'(sum) >> 8);
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] exp_v);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got_v, exp_v);
    err_count++;
  endtask

  task automatic check_frame();
    tel_frame_t e;
    if (frames_due.size() == 0) begin
      report_mismatch("unexpected frame beat", m_data[63:0], 64'd0);
      return;
    end
    e = frames_due.pop_front();
    if (m_data[15:0] !== e.counter) report_mismatch("frame_counter", m_data[15:0], e.counter);
    if (m_data[59:16] !== e.speed) report_mismatch("speed_rpm", m_data[59:16], e.speed);
    if (m_data[103:60] !== e.voltage)
      report_mismatch("bus_voltage", m_data[103:60], e.voltage);
    if (m_data[147:104] !== e.current)
      report_mismatch("bus_current", m_data[147:104], e.current);
    if (m_data[192:148] !== e.temp)
      report_mismatch("temperature_k", m_data[192:148], e.temp);
    if (m_data[236:193] !== e.throttle)
      report_mismatch("throttle_pct", m_data[236:193], e.throttle);
    if (m_data[239:237] !== 3'd0) report_mismatch("padding", m_data[239:237], 64'd0);
  endtask

  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && m_valid && m_ready) check_frame();
      if (sink_stall_left == 0 && sink_idle_en) sink_stall_left = pick_gap();
      if (sink_hold_left > 0) begin
        m_ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_stall_left > 0) begin
        m_ready <= 1'b0;
        sink_stall_left--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic ev);
    int unsigned gap;
    int i;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= ev;
    do @(posedge clk); while (!s_ready);
    for (i = 0; i < FRAME_BYTES - 1; i++) win_bytes[i] = win_bytes[i+1];
    win_bytes[FRAME_BYTES-1] = b;
    if (ev && win_bytes[0] == HDR_FIRST && win_bytes[1] == HDR_SECOND)
      frames_due.push_back(decode_frame());
    items_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input escp_reg_e idx, input logic [GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_VOLTAGE_GAIN:   cfg_model.voltage_gain = val;
      REG_RPM_GAIN:       cfg_model.rpm_gain = val;
      REG_CURRENT_GAIN:   cfg_model.current_gain = val;
      REG_THROTTLE_GAIN:  cfg_model.throttle_gain = val;
      REG_TEMP_SCALE:     cfg_model.temp_scale = val;
      REG_TEMP_OFFSET:    cfg_model.temp_offset = val[OFFS_W-1:0];
      REG_TEMP_BITS_MASK: cfg_model.temp_bits_mask = val[15:0];
      REG_POLE_COUNT:     cfg_model.pole_count = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] vg, input logic [GAIN_W-1:0] rg,
                              input logic [GAIN_W-1:0] cg, input logic [GAIN_W-1:0] tg,
                              input logic [GAIN_W-1:0] sl, input logic [GAIN_W-1:0] of,
                              input logic [GAIN_W-1:0] mk, input logic [GAIN_W-1:0] pc);
    wait_drained();
    write_reg(REG_VOLTAGE_GAIN, vg);
    write_reg(REG_RPM_GAIN, rg);
    write_reg(REG_CURRENT_GAIN, cg);
    write_reg(REG_THROTTLE_GAIN, tg);
    write_reg(REG_TEMP_SCALE, sl);
    write_reg(REG_TEMP_OFFSET, of);
    write_reg(REG_TEMP_BITS_MASK, mk);
    write_reg(REG_POLE_COUNT, pc);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input bit broken);
    logic [7:0]  fb [FRAME_BYTES];
    int unsigned field_pos [6] = '{OFS_COUNTER, OFS_THROTTLE, OFS_RPM, OFS_VOLTAGE,
                                   OFS_CURRENT, OFS_TEMP};
    logic [15:0] v;
    int          k;
    for (k = 0; k < FRAME_BYTES; k++) fb[k] = 8'($urandom);
    fb[0] = HDR_FIRST;
    fb[1] = HDR_SECOND;
    for (k = 0; k < 6; k++) begin
      v = pick16();
      fb[field_pos[k]] = v[15:8];
      fb[field_pos[k]+1] = v[7:0];
    end
    if (broken) fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    for (k = 0; k < FRAME_BYTES; k++)
      send_beat(fb[k], (k == FRAME_BYTES - 1) || ($urandom_range(0, 9) == 0));
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(1, 8);
    repeat (n) begin
      r = $urandom_range(0, 5);
      send_beat((r == 0) ? HDR_FIRST : (r == 1) ? HDR_SECOND : 8'($urandom),
                1'($urandom));
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned r;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_frame(1'b0);
      else if (r < 88) send_frame(1'b1);
      else send_noise();
    end
  endtask

  task automatic test_directed();
    int k;
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(HDR_FIRST, 1'b1);
    send_beat(HDR_SECOND, 1'b1);
    for (k = 2; k < FRAME_BYTES; k++) send_beat(8'hFF, 1'b1);
  endtask

  task automatic test_default_regs();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    run_traffic(150);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    run_traffic(150);
  endtask

  task automatic test_extreme_regs();
    program_regs({GAIN_W{1'b1}}, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, {GAIN_W{1'b1}},
                 36'h8_0000_0000, 36'h0_8000_0000, 36'h0_0000_FFFF, 36'd0);
    run_traffic(200);
    program_regs(36'd0, 36'd0, 36'd0, 36'd0,
                 36'h7_FFFF_FFFF, 36'h0_7FFF_FFFF, 36'd0, 36'd255);
    run_traffic(100);
    program_regs(36'd1, 36'd1, 36'd1, 36'd1,
                 36'h7_FFFF_FFFF, 36'hF_8000_0000, 36'hF_FFFF_FFFF, 36'hF_FFFF_FF01);
    run_traffic(100);
  endtask

  task automatic test_output_stall();
    wait_drained();
    src_idle_en = 1'b0;
    sink_hold_left = 1500;
    repeat (6) send_frame(1'b0);
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_regs();
    repeat (5) begin
      program_regs(rand36(), rand36(), rand36(), rand36(),
                   rand36(), rand36(), rand36(), rand36());
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      run_traffic(160);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    s_valid = 1'b0;
    s_data = 8'd0;
    s_user = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_VOLTAGE_GAIN;
    cfg_wdata = '0;
    foreach (win_bytes[i]) win_bytes[i] = 8'd0;
    cfg_model.voltage_gain = 36'd16777216;
    cfg_model.rpm_gain = 36'd16777216;
    cfg_model.current_gain = 36'd16777216;
    cfg_model.throttle_gain = 36'd16777216;
    cfg_model.temp_scale = 36'd16777216;
    cfg_model.temp_offset = 32'd0;
    cfg_model.temp_bits_mask = 16'hFFFF;
    cfg_model.pole_count = 8'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_regs();
    test_extreme_regs();
    test_output_stall();
    test_random_regs();
    wait_drained();
    if (frames_due.size() != 0) report_mismatch("frames never delivered", frames_due.size(), 0);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/escp_pkg.sv
hdl/escp_engine.sv
hdl/esc_telemetry_frame_parser_core.sv
verif/testbench.sv
